// File: sv/sfls_pkg.sv
// Shared types and constants for the supervisory-frame link setup block.
// No dependencies; every other file but sv/sfls_if.sv imports this package.
package sfls_pkg;

  localparam logic [7:0] FRAME_FLAG = 8'h7E;

  // Command codes of an input word
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_BYTE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Link states
  localparam logic [1:0] LS_IDLE = 2'd0;
  localparam logic [1:0] LS_WAIT = 2'd1;
  localparam logic [1:0] LS_CONN = 2'd2;
  localparam logic [1:0] LS_FAIL = 2'd3;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_ROLE          = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADDRESS_BYTE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SET_CONTROL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UA_CONTROL    = 3'd5;

  // Register reset values
  localparam logic        RST_ROLE          = 1'b0;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd3;
  localparam logic [3:0]  RST_MAX_ATTEMPTS  = 4'd3;
  localparam logic [7:0]  RST_ADDRESS_BYTE  = 8'h03;
  localparam logic [7:0]  RST_SET_CONTROL   = 8'h03;
  localparam logic [7:0]  RST_UA_CONTROL    = 8'h07;

  localparam logic [2:0] FRAME_LAST_IDX = 3'd4;

  localparam int QUEUE_DEPTH_DEFAULT = 2;

  typedef struct packed {
    logic        role;
    logic [15:0] timeout_ticks;
    logic [3:0]  max_attempts;
    logic [7:0]  address_byte;
    logic [7:0]  set_control;
    logic [7:0]  ua_control;
  } cfg_t;

  // One job handed from the front to the back: what to emit for one input
  typedef struct packed {
    logic       send;
    logic [7:0] ctl;
    logic [7:0] addr;
    logic [1:0] link_state;
    logic [3:0] attempts;
  } job_t;

endpackage

// File: sv/sfls_if.sv
// Valid/ready channel interfaces for input and result words.
// Depends on nothing; payload widths follow the block's field list.
interface sfls_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface sfls_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;
  logic [1:0] link_state;
  logic [3:0] attempts_used;

  modport source (output valid, tx_valid, tx_byte, last, link_state, attempts_used,
                  input ready);
  modport sink   (input valid, tx_valid, tx_byte, last, link_state, attempts_used,
                  output ready);
endinterface

// File: sv/supervision_frame_link_setup.sv
// Link establishment over a byte link with five-byte supervisory frames
// (flag, address, control, address XOR control, flag). Each input word is a
// start command, one received byte or one timer tick. The front end takes a
// word whenever the job queue has room, updates the parser, link state,
// attempt counter and tick timer, and queues one job. The back end drives
// results one per cycle while jobs wait and out_ch.ready is high: one result
// with tx_valid low, or the five bytes of a SET or UA frame with last on the
// fifth. An input that sends a frame therefore takes five results and any
// other input one; the back-end serializer sets the sustained rate, and the
// queue of QueueDepth jobs lets inputs keep arriving while a frame goes out.
// Configuration registers are written through cfg_we/cfg_index/cfg_data.
module supervision_frame_link_setup
  import sfls_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  sfls_in_if.sink               in_ch,
  sfls_out_if.source            out_ch
);

  cfg_t cfg;
  job_t front_job;
  job_t q_job;
  logic q_full;
  logic q_empty;
  logic q_pop;
  logic accept;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.role          <= RST_ROLE;
      cfg.timeout_ticks <= RST_TIMEOUT_TICKS;
      cfg.max_attempts  <= RST_MAX_ATTEMPTS;
      cfg.address_byte  <= RST_ADDRESS_BYTE;
      cfg.set_control   <= RST_SET_CONTROL;
      cfg.ua_control    <= RST_UA_CONTROL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_ROLE:          cfg.role          <= cfg_data[0];
        CFG_TIMEOUT_TICKS: cfg.timeout_ticks <= cfg_data;
        CFG_MAX_ATTEMPTS:  cfg.max_attempts  <= cfg_data[3:0];
        CFG_ADDRESS_BYTE:  cfg.address_byte  <= cfg_data[7:0];
        CFG_SET_CONTROL:   cfg.set_control   <= cfg_data[7:0];
        CFG_UA_CONTROL:    cfg.ua_control    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Accept a word whenever the queue can take its job
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  sfls_front u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .accept  (accept),
    .command (in_ch.command),
    .rx_byte (in_ch.rx_byte),
    .job     (front_job)
  );

  sfls_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_job (front_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (q_job),
    .empty    (q_empty)
  );

  sfls_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_job   (q_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // A result without a frame byte is always the only result of its word
  a_idle_single: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.tx_valid) |-> out_ch.last)
    else $error("idle result not marked last");

  // Every frame ends on a flag byte
  a_frame_end_flag: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.tx_valid && out_ch.last) |-> (out_ch.tx_byte == FRAME_FLAG))
    else $error("frame does not end with a flag");

  // A frame in progress keeps going without a gap
  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> (out_ch.valid && out_ch.tx_valid))
    else $error("frame interrupted");

  // The queue never pops when empty
  a_no_empty_pop: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty)
    else $error("pop from empty queue");

endmodule

// File: sv/sfls_front.sv
// Front end: frame parser, link state, attempt counter and tick timer.
// Uses sfls_pkg; produces one job per accepted input word.
module sfls_front
  import sfls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       accept,
  input  logic [1:0] command,
  input  logic [7:0] rx_byte,
  output job_t       job
);

  localparam logic [2:0] PS_START = 3'd0;
  localparam logic [2:0] PS_FLAG  = 3'd1;
  localparam logic [2:0] PS_ADDR  = 3'd2;
  localparam logic [2:0] PS_CTRL  = 3'd3;
  localparam logic [2:0] PS_BCC   = 3'd4;

  logic [2:0]  parse_state, parse_state_next;
  logic [1:0]  link_status, link_status_next;
  logic [3:0]  timeout_count, timeout_count_next;
  logic [15:0] tick_timer, tick_timer_next;

  logic        tx_role;
  logic [7:0]  want;
  logic        frame_done;
  logic [15:0] timer_dec;
  logic [3:0]  count_inc;
  logic        send;
  logic [7:0]  ctl;

  assign tx_role   = !cfg.role;
  assign want      = tx_role ? cfg.ua_control : cfg.set_control;
  assign timer_dec = (tick_timer != 16'd0) ? tick_timer - 16'd1 : 16'd0;
  assign count_inc = (timeout_count == 4'hF) ? timeout_count : timeout_count + 4'd1;

  always_comb begin
    parse_state_next   = parse_state;
    link_status_next   = link_status;
    timeout_count_next = timeout_count;
    tick_timer_next    = tick_timer;
    frame_done         = 1'b0;
    send               = 1'b0;
    ctl                = cfg.set_control;
    case (command)
      CMD_START: begin
        timeout_count_next = 4'd0;
        link_status_next   = LS_WAIT;
        if (tx_role) begin
          tick_timer_next = cfg.timeout_ticks;
          send            = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (link_status == LS_WAIT) begin
          case (parse_state)
            PS_START: begin
              if (rx_byte == FRAME_FLAG) parse_state_next = PS_FLAG;
            end
            PS_FLAG: begin
              if (rx_byte == cfg.address_byte) parse_state_next = PS_ADDR;
              else if (rx_byte != FRAME_FLAG) parse_state_next = PS_START;
            end
            PS_ADDR: begin
              if (rx_byte == want) parse_state_next = PS_CTRL;
              else if (rx_byte == FRAME_FLAG) parse_state_next = PS_FLAG;
              else parse_state_next = PS_START;
            end
            PS_CTRL: begin
              if (rx_byte == (cfg.address_byte ^ want)) parse_state_next = PS_BCC;
              else if (rx_byte == FRAME_FLAG) parse_state_next = PS_FLAG;
              else parse_state_next = PS_START;
            end
            PS_BCC: begin
              parse_state_next = PS_START;
              frame_done       = (rx_byte == FRAME_FLAG);
            end
            default: parse_state_next = PS_START;
          endcase
          if (frame_done) begin
            link_status_next = LS_CONN;
            tick_timer_next  = 16'd0;
            if (!tx_role) begin
              send = 1'b1;
              ctl  = cfg.ua_control;
            end
          end
        end
      end
      CMD_TICK: begin
        if (tx_role && link_status == LS_WAIT) begin
          tick_timer_next = timer_dec;
          if (timer_dec == 16'd0) begin
            timeout_count_next = count_inc;
            if (count_inc >= cfg.max_attempts) begin
              link_status_next = LS_FAIL;
            end else begin
              tick_timer_next = cfg.timeout_ticks;
              send            = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state   <= PS_START;
      link_status   <= LS_IDLE;
      timeout_count <= 4'd0;
      tick_timer    <= 16'd0;
    end else if (accept) begin
      parse_state   <= parse_state_next;
      link_status   <= link_status_next;
      timeout_count <= timeout_count_next;
      tick_timer    <= tick_timer_next;
    end
  end

  assign job.send       = send;
  assign job.ctl        = ctl;
  assign job.addr       = cfg.address_byte;
  assign job.link_state = link_status_next;
  assign job.attempts   = timeout_count_next;

endmodule

// File: sv/sfls_queue.sv
// Short job queue between front and back.
// Uses sfls_pkg for job_t; depth set by the Depth parameter (at least 2).
module sfls_queue
  import sfls_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output job_t pop_job,
  output logic empty
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full    = (count == FullCnt);
  assign empty   = (count == '0);
  assign pop_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      if (push && !pop)      count <= count + CntW'(1);
      else if (pop && !push) count <= count - CntW'(1);
    end
  end

endmodule

// File: sv/sfls_back.sv
// Back end: turns one job into one idle result or the five bytes of a frame.
// Uses sfls_pkg; holds the current job in a register that drives the output.
module sfls_back
  import sfls_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  job_t     q_job,
  input  logic     q_empty,
  output logic     q_pop,
  sfls_out_if.source out_ch
);

  logic       busy;
  job_t       cur;
  logic [2:0] idx;
  logic       is_last;
  logic       done;

  assign is_last = !cur.send || (idx == FRAME_LAST_IDX);
  assign done    = out_ch.valid && out_ch.ready && is_last;
  assign q_pop   = !q_empty && (!busy || done);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (q_pop) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (done) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (out_ch.valid && out_ch.ready) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_job;
  end

  always_comb begin
    case (idx)
      3'd0:    out_ch.tx_byte = FRAME_FLAG;
      3'd1:    out_ch.tx_byte = cur.addr;
      3'd2:    out_ch.tx_byte = cur.ctl;
      3'd3:    out_ch.tx_byte = cur.addr ^ cur.ctl;
      default: out_ch.tx_byte = FRAME_FLAG;
    endcase
    if (!cur.send) out_ch.tx_byte = 8'd0;
  end

  assign out_ch.valid         = busy;
  assign out_ch.tx_valid      = cur.send;
  assign out_ch.last          = is_last;
  assign out_ch.link_state    = cur.link_state;
  assign out_ch.attempts_used = cur.attempts;

endmodule

// File: dv/testbench.sv
// Self-checking bench for supervision_frame_link_setup: random and directed
// start/byte/tick words in, every result word checked against a local model.
// Depends on sfls_pkg and the sfls_in_if/sfls_out_if interfaces from sv/.
module testbench
  import sfls_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // Command code 3 is unused by the block; it must leave everything alone.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_WORDS = 180;
  localparam int unsigned MAX_REPORTS = 100;

  // Receive parser positions: hunting for the opening flag, then one step per
  // field that matched so far.
  typedef enum logic [2:0] {
    PARSE_HUNT,
    PARSE_FLAG,
    PARSE_ADDR,
    PARSE_CTRL,
    PARSE_BCC
  } parse_pos_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
  } link_word_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] link_state;
    logic [3:0] attempts_used;
  } link_result_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sfls_in_if in_ch ();
  sfls_out_if out_ch ();

  supervision_frame_link_setup dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #5ns clk = ~clk;

  // Local copy of the configuration, starting at the register reset values
  logic        cfg_role = RST_ROLE;
  logic [15:0] cfg_ticks = RST_TIMEOUT_TICKS;
  logic [3:0]  cfg_max = RST_MAX_ATTEMPTS;
  logic [7:0]  cfg_addr = RST_ADDRESS_BYTE;
  logic [7:0]  cfg_set_ctl = RST_SET_CONTROL;
  logic [7:0]  cfg_ua_ctl = RST_UA_CONTROL;

  // Link model state
  parse_pos_e  parse_pos = PARSE_HUNT;
  logic [1:0]  link = LS_IDLE;
  logic [3:0]  tries = 4'd0;
  logic [15:0] tick_timer = 16'd0;

  link_word_t   pending_words[$];
  link_result_t due_results[$];

  int unsigned fail_count = 0;
  int unsigned words_queued = 0;
  int unsigned cycles = 0;

  // Handshake flags: set at the rising edge, consumed at the falling edge
  bit in_taken = 1'b0;
  bit out_taken = 1'b0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int unsigned in_gap = 0;
  int unsigned out_stall = 0;

  // ---------------------------------------------------------------------------
  // Link model
  // ---------------------------------------------------------------------------

  // Advance the receive parser by one byte; return 1 when a complete frame
  // with control byte ctl closes on this byte. Any flag resynchronizes.
  function automatic bit frame_ends_here(input logic [7:0] b, input logic [7:0] ctl);
    bit done;
    done = 1'b0;
    case (parse_pos)
      PARSE_HUNT: if (b == FRAME_FLAG) parse_pos = PARSE_FLAG;
      PARSE_FLAG: begin
        if (b == cfg_addr) parse_pos = PARSE_ADDR;
        else if (b != FRAME_FLAG) parse_pos = PARSE_HUNT;
      end
      PARSE_ADDR: begin
        if (b == ctl) parse_pos = PARSE_CTRL;
        else if (b == FRAME_FLAG) parse_pos = PARSE_FLAG;
        else parse_pos = PARSE_HUNT;
      end
      PARSE_CTRL: begin
        if (b == (cfg_addr ^ ctl)) parse_pos = PARSE_BCC;
        else if (b == FRAME_FLAG) parse_pos = PARSE_FLAG;
        else parse_pos = PARSE_HUNT;
      end
      PARSE_BCC: begin
        parse_pos = PARSE_HUNT;
        done = (b == FRAME_FLAG);
      end
      default: parse_pos = PARSE_HUNT;
    endcase
    return done;
  endfunction

  // Apply one accepted word to the model and queue the result words it owes:
  // five frame bytes when a SET or UA goes out, else a single idle result.
  task automatic advance_link_model(input logic [1:0] cmd, input logic [7:0] b);
    logic       tx_role;
    logic       send;
    logic [7:0] ctl;
    logic [7:0] frame[5];
    link_result_t r;
    int n;
    tx_role = (cfg_role == 1'b0);
    send = 1'b0;
    ctl = cfg_set_ctl;
    case (cmd)
      CMD_START: begin
        tries = 4'd0;
        link = LS_WAIT;
        if (tx_role) begin
          tick_timer = cfg_ticks;
          send = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (link == LS_WAIT) begin
          if (frame_ends_here(b, tx_role ? cfg_ua_ctl : cfg_set_ctl)) begin
            link = LS_CONN;
            tick_timer = 16'd0;
            if (!tx_role) begin
              send = 1'b1;
              ctl = cfg_ua_ctl;
            end
          end
        end
      end
      CMD_TICK: begin
        if (tx_role && link == LS_WAIT) begin
          if (tick_timer != 16'd0) tick_timer = tick_timer - 16'd1;
          if (tick_timer == 16'd0) begin
            // Timeout: count it, then either give up or resend SET
            if (tries != 4'd15) tries = tries + 4'd1;
            if (tries >= cfg_max) begin
              link = LS_FAIL;
            end else begin
              tick_timer = cfg_ticks;
              send = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    frame[0] = FRAME_FLAG;
    frame[1] = cfg_addr;
    frame[2] = ctl;
    frame[3] = cfg_addr ^ ctl;
    frame[4] = FRAME_FLAG;
    n = send ? 5 : 1;
    for (int k = 0; k < n; k++) begin
      r.tx_valid = send;
      r.tx_byte = send ? frame[k] : 8'h00;
      r.last = (k == n - 1);
      r.link_state = link;
      r.attempts_used = tries;
      due_results.push_back(r);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: input words change at the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    link_word_t w;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_taken) begin
      if (in_taken) begin
        // Word just went in: occasionally flip between bursts and gappy traffic
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 19);
        in_taken = 1'b0;
      end
      if (in_gap == 0 && pending_words.size() != 0) begin
        w = pending_words.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.command <= w.command;
        in_ch.rx_byte <= w.rx_byte;
      end else begin
        in_ch.valid <= 1'b0;
        if (in_gap != 0) in_gap--;
      end
    end
  end

  // Result side back-pressure: draw a fresh stall after each accepted word
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_taken) begin
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        out_stall = out_burst ? 0 : $urandom_range(0, 19);
        out_taken = 1'b0;
      end
      if (out_stall != 0) begin
        out_ch.ready <= 1'b0;
        out_stall--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on input handshakes, check on output handshakes.
  // Inputs are handled first so a same-edge result still finds its entry.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    link_result_t want;
    link_result_t got;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) begin
        in_taken = 1'b1;
        advance_link_model(in_ch.command, in_ch.rx_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        out_taken = 1'b1;
        got.tx_valid = out_ch.tx_valid;
        got.tx_byte = out_ch.tx_byte;
        got.last = out_ch.last;
        got.link_state = out_ch.link_state;
        got.attempts_used = out_ch.attempts_used;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display({"%0t: unexpected result: tx_valid=%0b tx_byte=%02h last=%0b ",
                      "state=%0d tries=%0d"},
                     $time, got.tx_valid, got.tx_byte, got.last, got.link_state,
                     got.attempts_used);
        end else begin
          want = due_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"%0t: mismatch: expected tx_valid=%0b tx_byte=%02h last=%0b state=%0d ",
                        "tries=%0d, actual tx_valid=%0b tx_byte=%02h last=%0b state=%0d tries=%0d"},
                       $time, want.tx_valid, want.tx_byte, want.last, want.link_state,
                       want.attempts_used, got.tx_valid, got.tx_byte, got.last,
                       got.link_state, got.attempts_used);
          end
        end
      end
    end
  end

  // Watchdog: a stuck handshake ends the run as a failure
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_word(input logic [1:0] cmd, input logic [7:0] b);
    link_word_t w;
    w.command = cmd;
    w.rx_byte = b;
    pending_words.push_back(w);
    words_queued++;
  endtask

  // Queue a five-byte frame with control ctl; when broken, damage it by
  // replacing one byte or cutting it short. Sometimes lead with a spare flag.
  task automatic push_frame(input logic [7:0] ctl, input bit broken);
    logic [7:0] f[5];
    int bad_pos;
    int len;
    f[0] = FRAME_FLAG;
    f[1] = cfg_addr;
    f[2] = ctl;
    f[3] = cfg_addr ^ ctl;
    f[4] = FRAME_FLAG;
    len = 5;
    if ($urandom_range(0, 4) == 0) push_word(CMD_BYTE, FRAME_FLAG);
    if (broken) begin
      bad_pos = $urandom_range(0, 4);
      if ($urandom_range(0, 2) == 0) len = bad_pos + 1;
      else f[bad_pos] = 8'($urandom_range(0, 255));
    end
    for (int k = 0; k < len; k++) push_word(CMD_BYTE, f[k]);
  endtask

  // Hold until every word went in and every result came back, then let the
  // back end settle.
  task automatic drain_block();
    @(negedge clk);
    while (pending_words.size() != 0 || in_ch.valid || due_results.size() != 0)
      @(negedge clk);
    repeat (5) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
  endtask

  // Program every register; only called while the block is idle.
  task automatic program_link(input logic role, input logic [15:0] ticks, input logic [3:0] tmax,
                              input logic [7:0] addr, input logic [7:0] set_ctl,
                              input logic [7:0] ua_ctl);
    write_reg(CFG_ROLE, {15'd0, role});
    write_reg(CFG_TIMEOUT_TICKS, ticks);
    write_reg(CFG_MAX_ATTEMPTS, {12'd0, tmax});
    write_reg(CFG_ADDRESS_BYTE, {8'd0, addr});
    write_reg(CFG_SET_CONTROL, {8'd0, set_ctl});
    write_reg(CFG_UA_CONTROL, {8'd0, ua_ctl});
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_role = role;
    cfg_ticks = ticks;
    cfg_max = tmax;
    cfg_addr = addr;
    cfg_set_ctl = set_ctl;
    cfg_ua_ctl = ua_ctl;
  endtask

  // Bytes skewed toward the corners and toward the flag value itself
  function automatic logic [7:0] pick_field_byte();
    case ($urandom_range(0, 5))
      0: return 8'h00;
      1: return 8'hFF;
      2: return FRAME_FLAG;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One random phase: mostly start-then-handshake sequences, with ticks,
  // damaged frames, stray bytes, restarts and the unused command mixed in.
  task automatic fill_random_phase(input int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    logic [7:0] wanted_ctl;
    wanted_ctl = cfg_role ? cfg_set_ctl : cfg_ua_ctl;
    stop_at = words_queued + n;
    push_word(CMD_START, 8'($urandom_range(0, 255)));
    while (words_queued < stop_at) begin
      r = $urandom_range(0, 99);
      if (r < 35) push_frame(wanted_ctl, 1'b0);
      else if (r < 45) push_frame($urandom_range(0, 1) ? wanted_ctl : pick_field_byte(), 1'b1);
      else if (r < 70)
        repeat ($urandom_range(1, 4)) push_word(CMD_TICK, 8'($urandom_range(0, 255)));
      else if (r < 80) push_word(CMD_BYTE, pick_field_byte());
      else if (r < 93) push_word(CMD_START, 8'($urandom_range(0, 255)));
      else push_word(CMD_NONE, 8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned random_start;
    logic [15:0] ticks;
    logic [3:0]  tmax;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_START;
    in_ch.rx_byte = 8'h00;
    out_ch.ready = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed, reset configuration (transmitter, three ticks, three tries).
    // Idle link: byte, tick and the unused command change nothing.
    push_word(CMD_BYTE, FRAME_FLAG);
    push_word(CMD_TICK, 8'hFF);
    push_word(CMD_NONE, 8'hA5);
    // Start sends SET; three timeouts of three ticks each end in failure,
    // with SET resent after the first two.
    push_word(CMD_START, 8'h00);
    repeat (9) push_word(CMD_TICK, 8'h00);
    // Failed link ignores bytes; restart and connect on a UA that follows a
    // doubled opening flag.
    push_word(CMD_BYTE, FRAME_FLAG);
    push_word(CMD_START, 8'hFF);
    push_word(CMD_BYTE, FRAME_FLAG);
    push_frame(cfg_ua_ctl, 1'b0);
    drain_block();

    // Directed, receiver at the extremes: ticks ignored, SET answered by UA.
    program_link(1'b1, 16'd1, 4'd15, 8'hFF, 8'h00, 8'hFF);
    push_word(CMD_START, 8'h00);
    push_word(CMD_TICK, 8'h00);
    push_frame(cfg_set_ctl, 1'b0);
    drain_block();

    // Random phases, each under a fresh setting
    random_start = words_queued;
    while (words_queued - random_start < RANDOM_WORDS) begin
      case ($urandom_range(0, 9))
        0: ticks = 16'd1;
        1: ticks = 16'hFFFF;
        2: ticks = 16'($urandom_range(1, 65535));
        default: ticks = 16'($urandom_range(1, 4));
      endcase
      case ($urandom_range(0, 5))
        0: tmax = 4'd1;
        1: tmax = 4'd15;
        default: tmax = 4'($urandom_range(1, 6));
      endcase
      program_link(1'($urandom_range(0, 1)), ticks, tmax, pick_field_byte(),
                   pick_field_byte(), pick_field_byte());
      fill_random_phase($urandom_range(15, 35));
      drain_block();
    end

    repeat (20) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
